[sv/adc_block_average_smoother_defines.svh]
// Assertion macros shared by the smoother RTL.
`ifndef ADC_BLOCK_AVERAGE_SMOOTHER_DEFINES_SVH
`define ADC_BLOCK_AVERAGE_SMOOTHER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ABAS_ASSERT_IMP(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("abas: same-cycle check failed");

// Next-cycle implication.
`define ABAS_ASSERT_NXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("abas: next-cycle check failed");

`endif

[sv/abas_pkg.sv]
// Types and constants shared by the ADC block-average smoother.
package abas_pkg;

   localparam int unsigned SAMPLE_WIDTH = 12;
   localparam int unsigned WARMUP_WIDTH = 4;

   localparam logic [WARMUP_WIDTH-1:0] WARMUP_RESET = 4'd5;
   localparam logic [SAMPLE_WIDTH-1:0] REF_RESET    = 12'd3100;

   localparam logic CH_REFERENCE = 1'b0;
   localparam logic CH_SENSOR    = 1'b1;

   // (old*75 + mean*25)/100 reduces exactly to (old*3 + mean)/4
   localparam int unsigned BLEND_SHIFT = 2;

   typedef struct packed {
      logic                    next_channel;
      logic [SAMPLE_WIDTH-1:0] reference_level;
      logic [SAMPLE_WIDTH-1:0] filtered_level;
      logic                    level_updated;
      logic                    reference_updated;
   } result_type;

endpackage

[sv/adc_block_average_smoother.sv]
// A request taken into the input register is written to the result register
// when that register can advance. Throughput: one request per cycle unless
// the result is stalled; a stalled result still lets one request in.
// The input register and the state update plus mean/blend logic form one pass.
// Reset is synchronous, active high: reference channel selected, reference
// level 3100, filtered level 0, warm-up setting 5, block cleared.
`include "adc_block_average_smoother_defines.svh"

module adc_block_average_smoother #(
   parameter int unsigned BLOCK_SAMPLES = 50,
   parameter int unsigned SAMPLE_BITS   = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [abas_pkg::WARMUP_WIDTH-1:0]     csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [abas_pkg::SAMPLE_WIDTH-1:0]     req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_next_channel,
   output logic [abas_pkg::SAMPLE_WIDTH-1:0]     rsp_reference_level,
   output logic [abas_pkg::SAMPLE_WIDTH-1:0]     rsp_filtered_level,
   output logic                                  rsp_level_updated,
   output logic                                  rsp_reference_updated
);

   logic                                 req_valid_ff, req_valid_in;
   logic [abas_pkg::SAMPLE_WIDTH-1:0]    req_sample_ff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   abas_pkg::result_type                 rsp_data_ff;
   abas_pkg::result_type                 result;
   logic                                 advance;
   logic                                 commit;
   logic                                 req_take;

   // result register can take a new value this cycle
   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign commit   = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;
   assign req_take = req_valid && !req_stall;

   assign req_valid_in = req_take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance ? req_valid_ff : rsp_valid_ff;

   abas_core #(
      .BLOCK_SAMPLES (BLOCK_SAMPLES),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .commit           (commit),
      .sample           (req_sample_ff),
      .result           (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_sample_ff <= req_sample;
      end
      if (commit) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_next_channel      = rsp_data_ff.next_channel;
   assign rsp_reference_level   = rsp_data_ff.reference_level;
   assign rsp_filtered_level    = rsp_data_ff.filtered_level;
   assign rsp_level_updated     = rsp_data_ff.level_updated;
   assign rsp_reference_updated = rsp_data_ff.reference_updated;

   `ABAS_ASSERT_IMP(a_ref_selects_sensor, clock, reset,
                    rsp_valid && rsp_reference_updated,
                    rsp_next_channel == abas_pkg::CH_SENSOR && !rsp_level_updated)
   `ABAS_ASSERT_IMP(a_ref_return_on_blend, clock, reset,
                    rsp_valid && rsp_next_channel == abas_pkg::CH_REFERENCE,
                    rsp_level_updated)
   `ABAS_ASSERT_NXT(a_commit_gives_result, clock, reset, commit, rsp_valid_ff)

endmodule

[sv/abas_core.sv]
// Smoother state, block accumulator, reciprocal mean and blend logic.
`include "adc_block_average_smoother_defines.svh"

module abas_core #(
   parameter int unsigned BLOCK_SAMPLES,
   parameter int unsigned SAMPLE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [abas_pkg::WARMUP_WIDTH-1:0]      csr_write_data,
   input  logic                                   commit,
   input  logic [abas_pkg::SAMPLE_WIDTH-1:0]      sample,
   output abas_pkg::result_type                   result
);

   // effective sample width after the input mask
   localparam int unsigned EW   = (SAMPLE_BITS < abas_pkg::SAMPLE_WIDTH) ?
                                  SAMPLE_BITS : abas_pkg::SAMPLE_WIDTH;
   localparam int unsigned SUMW = EW + 8;
   localparam int unsigned CW   = $clog2(BLOCK_SAMPLES + 1);
   // floor(sum / BLOCK_SAMPLES) = (sum * MULT) >> SHIFT, exact for sum < 2**SUMW
   localparam int unsigned SHIFT = SUMW + $clog2(BLOCK_SAMPLES);
   localparam longint unsigned MULT =
      ((64'd1 << SHIFT) + BLOCK_SAMPLES - 1) / BLOCK_SAMPLES;
   localparam int unsigned MW   = SUMW + 2;
   localparam int unsigned PW   = SUMW + MW;

   logic [abas_pkg::WARMUP_WIDTH-1:0] warmup_samples_ff;
   logic                              channel_ff, channel_in;
   logic [EW-1:0]                     reference_ff, reference_in;
   logic [EW-1:0]                     level_ff, level_in;
   logic [abas_pkg::WARMUP_WIDTH-1:0] warmup_seen_ff, warmup_seen_in;
   logic [CW-1:0]                     block_count_ff, block_count_in;
   logic [SUMW-1:0]                   block_sum_ff, block_sum_in;

   logic [EW-1:0]   sample_m;
   logic [EW-1:0]   sample_even;
   logic            seed;
   logic            blend;
   logic [SUMW-1:0] sum_add;
   logic [CW-1:0]   count_inc;
   logic [MW-1:0]   mult_c;
   logic [PW-1:0]   product;
   logic [EW-1:0]   mean;
   logic [EW+1:0]   weighted;
   logic [EW-1:0]   blended;

   assign sample_m    = sample[EW-1:0];
   assign sample_even = {sample_m[EW-1:1], 1'b0};
   assign seed        = (channel_ff == abas_pkg::CH_SENSOR) &&
                        (warmup_seen_ff < warmup_samples_ff);
   assign sum_add     = block_sum_ff + SUMW'(sample_even);
   assign count_inc   = block_count_ff + CW'(1);
   assign blend       = (channel_ff == abas_pkg::CH_SENSOR) && !seed &&
                        (count_inc >= CW'(BLOCK_SAMPLES));
   assign mult_c      = MW'(MULT);
   assign product     = PW'(sum_add) * PW'(mult_c);
   assign mean        = product[SHIFT +: EW];
   assign weighted    = (EW+2)'({level_ff, 1'b0}) + (EW+2)'(level_ff) + (EW+2)'(mean);
   assign blended     = weighted[abas_pkg::BLEND_SHIFT +: EW];

   always_comb begin
      channel_in     = channel_ff;
      reference_in   = reference_ff;
      level_in       = level_ff;
      warmup_seen_in = warmup_seen_ff;
      block_count_in = block_count_ff;
      block_sum_in   = block_sum_ff;
      if (channel_ff == abas_pkg::CH_REFERENCE) begin
         reference_in = sample_m;
         channel_in   = abas_pkg::CH_SENSOR;
      end else if (seed) begin
         level_in       = sample_even;
         block_sum_in   = '0;
         warmup_seen_in = warmup_seen_ff + abas_pkg::WARMUP_WIDTH'(1);
      end else if (blend) begin
         level_in       = blended;
         block_count_in = '0;
         block_sum_in   = '0;
         channel_in     = abas_pkg::CH_REFERENCE;
      end else begin
         block_sum_in   = sum_add;
         block_count_in = count_inc;
      end
   end

   always_comb begin
      result.next_channel      = channel_in;
      result.reference_level   = abas_pkg::SAMPLE_WIDTH'(reference_in);
      result.filtered_level    = abas_pkg::SAMPLE_WIDTH'(level_in);
      result.level_updated     = seed || blend;
      result.reference_updated = (channel_ff == abas_pkg::CH_REFERENCE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         warmup_samples_ff <= abas_pkg::WARMUP_RESET;
      end else if (csr_write_enable) begin
         warmup_samples_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff     <= abas_pkg::CH_REFERENCE;
         reference_ff   <= abas_pkg::REF_RESET[EW-1:0];
         level_ff       <= '0;
         warmup_seen_ff <= '0;
         block_count_ff <= '0;
         block_sum_ff   <= '0;
      end else if (commit) begin
         channel_ff     <= channel_in;
         reference_ff   <= reference_in;
         level_ff       <= level_in;
         warmup_seen_ff <= warmup_seen_in;
         block_count_ff <= block_count_in;
         block_sum_ff   <= block_sum_in;
      end
   end

   `ABAS_ASSERT_IMP(a_count_below_block, clock, reset, 1'b1,
                    block_count_ff < CW'(BLOCK_SAMPLES))
   `ABAS_ASSERT_IMP(a_empty_block_zero_sum, clock, reset, block_count_ff == '0,
                    block_sum_ff == '0)
   `ABAS_ASSERT_NXT(a_blend_restarts_block, clock, reset, commit && blend,
                    block_count_ff == '0 && channel_ff == abas_pkg::CH_REFERENCE)

endmodule

[verif/adc_block_average_smoother_tb.sv]
// Self-checking testbench for the ADC block-average smoother with random flow control.
module adc_block_average_smoother_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned BLOCK_SAMPLES = 50;
   localparam int unsigned OLD_WEIGHT    = 75;
   localparam int unsigned NEW_WEIGHT    = 25;
   localparam int unsigned WEIGHT_TOTAL  = 100;
   localparam int unsigned DRAIN_CYCLES  = 6;
   localparam int unsigned PHASE_ITEMS   = 180;

   // Mirrors the smoother state and holds the results still owed by the block.
   class level_tracker;
      logic                              channel;
      logic [abas_pkg::SAMPLE_WIDTH-1:0] ref_level;
      logic [abas_pkg::SAMPLE_WIDTH-1:0] level;
      logic [abas_pkg::WARMUP_WIDTH-1:0] seen;
      logic [abas_pkg::WARMUP_WIDTH-1:0] warmup_limit;
      logic [7:0]                        count;
      logic [19:0]                       sum;
      abas_pkg::result_type              pending_levels[$];
      int unsigned                       mismatches;
      int unsigned                       n_requests, n_reference, n_seed, n_blend;

      function new();
         channel      = abas_pkg::CH_REFERENCE;
         ref_level    = abas_pkg::REF_RESET;
         level        = '0;
         seen         = '0;
         warmup_limit = abas_pkg::WARMUP_RESET;
         count        = '0;
         sum          = '0;
         mismatches   = 0;
         n_requests   = 0;
         n_reference  = 0;
         n_seed       = 0;
         n_blend      = 0;
      endfunction

      function int unsigned pending();
         return pending_levels.size();
      endfunction

      function void note_sample(logic [abas_pkg::SAMPLE_WIDTH-1:0] sample);
         abas_pkg::result_type              r;
         logic [abas_pkg::SAMPLE_WIDTH-1:0] even;
         int unsigned                       mean, blend;
         even = {sample[abas_pkg::SAMPLE_WIDTH-1:1], 1'b0};
         r.level_updated     = 1'b0;
         r.reference_updated = 1'b0;
         n_requests++;
         if (channel == abas_pkg::CH_REFERENCE) begin
            ref_level = sample;
            channel   = abas_pkg::CH_SENSOR;
            r.reference_updated = 1'b1;
            n_reference++;
         end else if (seen < warmup_limit) begin
            level = even;
            sum   = '0;
            seen  = seen + 1'b1;
            r.level_updated = 1'b1;
            n_seed++;
         end else begin
            sum   = sum + 20'(even);
            count = count + 1'b1;
            if (count >= BLOCK_SAMPLES) begin
               mean  = int'(sum) / BLOCK_SAMPLES;
               blend = (int'(level) * OLD_WEIGHT + mean * NEW_WEIGHT) / WEIGHT_TOTAL;
               level   = blend[abas_pkg::SAMPLE_WIDTH-1:0];
               count   = '0;
               sum     = '0;
               channel = abas_pkg::CH_REFERENCE;
               r.level_updated = 1'b1;
               n_blend++;
            end
         end
         r.next_channel    = channel;
         r.reference_level = ref_level;
         r.filtered_level  = level;
         pending_levels.push_back(r);
      endfunction

      function void check_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(abas_pkg::result_type got);
         abas_pkg::result_type want;
         if (pending_levels.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            mismatches++;
            return;
         end
         want = pending_levels.pop_front();
         check_field("next_channel", want.next_channel, got.next_channel);
         check_field("reference_level", want.reference_level, got.reference_level);
         check_field("filtered_level", want.filtered_level, got.filtered_level);
         check_field("level_updated", want.level_updated, got.level_updated);
         check_field("reference_updated", want.reference_updated, got.reference_updated);
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_write_enable = 1'b0;
   logic [abas_pkg::WARMUP_WIDTH-1:0] csr_write_data = '0;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [abas_pkg::SAMPLE_WIDTH-1:0] req_sample = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic                              rsp_next_channel;
   logic [abas_pkg::SAMPLE_WIDTH-1:0] rsp_reference_level;
   logic [abas_pkg::SAMPLE_WIDTH-1:0] rsp_filtered_level;
   logic                              rsp_level_updated;
   logic                              rsp_reference_updated;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned n_settings = 1;

   level_tracker tracker = new();

   adc_block_average_smoother #(
      .BLOCK_SAMPLES(BLOCK_SAMPLES),
      .SAMPLE_BITS  (abas_pkg::SAMPLE_WIDTH)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_sample           (req_sample),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_next_channel     (rsp_next_channel),
      .rsp_reference_level  (rsp_reference_level),
      .rsp_filtered_level   (rsp_filtered_level),
      .rsp_level_updated    (rsp_level_updated),
      .rsp_reference_updated(rsp_reference_updated)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_result({rsp_next_channel, rsp_reference_level, rsp_filtered_level,
                               rsp_level_updated, rsp_reference_updated});
   end

   task automatic send_sample(input logic [abas_pkg::SAMPLE_WIDTH-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (req_stall);
      tracker.note_sample(value);   // request taken at this edge
   endtask

   task automatic drain();
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_warmup(input logic [abas_pkg::WARMUP_WIDTH-1:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.warmup_limit = value;
      n_settings++;
   endtask

   // Mostly near a per-phase level so the smoothed value can reach the extremes.
   function automatic logic [abas_pkg::SAMPLE_WIDTH-1:0] pick_sample(
      logic [abas_pkg::SAMPLE_WIDTH-1:0] base);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return base ^ abas_pkg::SAMPLE_WIDTH'($urandom_range(0, 15));
      else if (roll < 65)
         return '0;
      else if (roll < 75)
         return '1;
      else
         return abas_pkg::SAMPLE_WIDTH'($urandom_range(0, 4095));
   endfunction

   initial begin
      logic [abas_pkg::SAMPLE_WIDTH-1:0] directed_samples[$];
      logic [abas_pkg::SAMPLE_WIDTH-1:0] bases[6];
      logic [abas_pkg::WARMUP_WIDTH-1:0] plan[5];
      // reference at max, five seeds with odd and even extremes, then accumulation
      directed_samples = '{12'hFFF, 12'h000, 12'hFFF, 12'h001, 12'h800, 12'h7FF,
                           12'hFFF, 12'h000, 12'hAAA, 12'h555, 12'hFFE, 12'h001,
                           12'h000, 12'hFFF, 12'h800, 12'h123, 12'hEDC, 12'h7FE,
                           12'hFFF, 12'h000};
      bases = '{12'h800, 12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'h000};
      bases[4] = abas_pkg::SAMPLE_WIDTH'($urandom_range(0, 4095));
      bases[5] = abas_pkg::SAMPLE_WIDTH'($urandom_range(0, 4095));
      // raising the limit after averaging started resumes seeding
      plan = '{4'd0, 4'd8, 4'd15, 4'd3, 4'd0};
      plan[4] = abas_pkg::WARMUP_WIDTH'($urandom_range(0, 15));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < 6; phase++) begin
         if (phase > 0)
            write_warmup(plan[phase-1]);
         send_idle_pct  = (phase < 2) ? 18 : (phase < 4) ? 75 : 0;
         recv_stall_pct = (phase < 2) ? 75 : (phase < 4) ? 18 : 0;
         if (phase == 0)
            foreach (directed_samples[i]) send_sample(directed_samples[i]);
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_sample(pick_sample(bases[phase]));
         req_valid <= 1'b0;
      end

      drain();
      $display("Run covered %0d requests: %0d reference, %0d seeding, %0d block blends",
               tracker.n_requests, tracker.n_reference, tracker.n_seed, tracker.n_blend);
      $display("Warm-up settings used: %0d, with sender and receiver flow-control pauses",
               n_settings);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Timeout with %0d results outstanding", tracker.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
